@@ hdl/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Request and response types, counter mode codes and counter update functions.
// ----------------------------------------------------------------------------
package tbp_pkg;

   typedef struct packed {
      logic [31:0] branch_pc;
      logic        outcome_taken;
   } req_type;

   typedef struct packed {
      logic predicted_taken;
      logic used_global;
      logic prediction_correct;
   } rsp_type;

   typedef enum logic {
      COUNTER_MODE_JUMP  = 1'b0,
      COUNTER_MODE_PLAIN = 1'b1
   } counter_mode_type;

   localparam logic [1:0] CTR2_MAX  = 2'd3;
   localparam logic [1:0] CTR2_HALF = 2'd2;
   localparam logic [2:0] CTR3_MAX  = 3'd7;
   localparam logic [2:0] CTR3_HALF = 3'd4;

   function automatic logic [1:0] bump_2bit(logic [1:0] v, logic up, counter_mode_type mode);
      logic [1:0] r;
      if (up) begin
         if (v == CTR2_MAX) r = CTR2_MAX;
         else if (mode == COUNTER_MODE_JUMP && v == CTR2_HALF - 2'd1) r = CTR2_MAX;
         else r = v + 2'd1;
      end else begin
         if (v == 2'd0) r = 2'd0;
         else if (mode == COUNTER_MODE_JUMP && v == CTR2_HALF) r = 2'd0;
         else r = v - 2'd1;
      end
      return r;
   endfunction

   function automatic logic [2:0] bump_3bit(logic [2:0] v, logic up, counter_mode_type mode);
      logic [2:0] r;
      if (up) begin
         if (v == CTR3_MAX) r = CTR3_MAX;
         else if (mode == COUNTER_MODE_JUMP && v == CTR3_HALF - 3'd1) r = CTR3_MAX;
         else r = v + 3'd1;
      end else begin
         if (v == 3'd0) r = 3'd0;
         else if (mode == COUNTER_MODE_JUMP && v == CTR3_HALF) r = 3'd0;
         else r = v - 3'd1;
      end
      return r;
   endfunction

endpackage

@@ hdl/tournament_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Chooser, global and local counter tables plus local histories in RAMs;
// each request is read, predicted and written back before the next is taken.
// ----------------------------------------------------------------------------
// A request passes through the lookup and update states; the update and its response
//   wait while an earlier response is still stalled. The lookup is set by the dependent
//   reads of the local history RAM and then the local counter RAM.
// Reset: a clearing pass writes every table entry to zero, one entry a cycle;
//   no request is taken meanwhile.
module tournament_branch_predictor #(
   parameter int CHOOSER_INDEX_BITS  = 12,
   parameter int GLOBAL_HISTORY_BITS = 12,
   parameter int LOCAL_INDEX_BITS    = 10,
   parameter int LOCAL_HISTORY_BITS  = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tbp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbp_pkg::rsp_type rsp_payload,
   input  logic             csr_write_en,
   input  logic             csr_write_data
);

   import tbp_pkg::*;

   localparam int MAX_A = (CHOOSER_INDEX_BITS > GLOBAL_HISTORY_BITS) ?
                          CHOOSER_INDEX_BITS : GLOBAL_HISTORY_BITS;
   localparam int MAX_B = (LOCAL_INDEX_BITS > LOCAL_HISTORY_BITS) ?
                          LOCAL_INDEX_BITS : LOCAL_HISTORY_BITS;
   localparam int CLR_BITS = (MAX_A > MAX_B) ? MAX_A : MAX_B;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_UPDATE
   } state_type;

   state_type                      state_ff;
   logic [CLR_BITS-1:0]            clr_ff;
   logic [31:0]                    pc_ff;
   logic                           taken_ff;
   logic [GLOBAL_HISTORY_BITS-1:0] ghist_ff;
   logic [GLOBAL_HISTORY_BITS-1:0] ghist_in;
   counter_mode_type               mode_ff;
   logic                           rsp_valid_ff;
   rsp_type                        rsp_ff;

   logic                          accept;
   logic                          upd_go;
   logic                          clearing;
   logic [31:0]                   pc_sel;
   logic [CHOOSER_INDEX_BITS-1:0] ch_addr;
   logic [LOCAL_INDEX_BITS-1:0]   lh_addr;

   logic [1:0]                    ch_rd;
   logic [1:0]                    gc_rd;
   logic [2:0]                    lc_rd;
   logic [LOCAL_HISTORY_BITS-1:0] lh_rd;

   logic                          use_global;
   logic                          pred;
   logic                          right;
   logic [1:0]                    ch_new;
   logic [1:0]                    gc_new;
   logic [2:0]                    lc_new;
   logic [LOCAL_HISTORY_BITS-1:0] lh_new;

   logic                           ch_we, gc_we, lc_we, lh_we;
   logic [CHOOSER_INDEX_BITS-1:0]  ch_wa;
   logic [GLOBAL_HISTORY_BITS-1:0] gc_wa;
   logic [LOCAL_HISTORY_BITS-1:0]  lc_wa;
   logic [LOCAL_INDEX_BITS-1:0]    lh_wa;
   logic [1:0]                     ch_wd, gc_wd;
   logic [2:0]                     lc_wd;
   logic [LOCAL_HISTORY_BITS-1:0]  lh_wd;

   assign clearing  = (state_ff == S_CLEAR);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign upd_go    = (state_ff == S_UPDATE) && !(rsp_valid_ff && rsp_stall);

   assign pc_sel  = (state_ff == S_IDLE) ? req_payload.branch_pc : pc_ff;
   assign ch_addr = pc_sel[CHOOSER_INDEX_BITS+1:2];
   assign lh_addr = pc_sel[LOCAL_INDEX_BITS+1:2];

   always_comb begin
      use_global = ch_rd[1];
      pred       = use_global ? gc_rd[1] : lc_rd[2];
      right      = (pred == taken_ff);
      ch_new     = bump_2bit(ch_rd, use_global == right, mode_ff);
      gc_new     = bump_2bit(gc_rd, taken_ff, mode_ff);
      lc_new     = bump_3bit(lc_rd, taken_ff, mode_ff);
      lh_new     = {lh_rd[LOCAL_HISTORY_BITS-2:0], taken_ff};
      ghist_in   = {ghist_ff[GLOBAL_HISTORY_BITS-2:0], taken_ff};
   end

   always_comb begin
      ch_we = clearing || upd_go;
      lh_we = clearing || upd_go;
      gc_we = clearing || (upd_go && use_global);
      lc_we = clearing || (upd_go && !use_global);
      if (clearing) begin
         ch_wa = clr_ff[CHOOSER_INDEX_BITS-1:0];
         gc_wa = clr_ff[GLOBAL_HISTORY_BITS-1:0];
         lc_wa = clr_ff[LOCAL_HISTORY_BITS-1:0];
         lh_wa = clr_ff[LOCAL_INDEX_BITS-1:0];
         ch_wd = '0;
         gc_wd = '0;
         lc_wd = '0;
         lh_wd = '0;
      end else begin
         ch_wa = pc_ff[CHOOSER_INDEX_BITS+1:2];
         gc_wa = ghist_ff;
         lc_wa = lh_rd;
         lh_wa = pc_ff[LOCAL_INDEX_BITS+1:2];
         ch_wd = ch_new;
         gc_wd = gc_new;
         lc_wd = lc_new;
         lh_wd = lh_new;
      end
   end

   tbp_ram #(.WIDTH(2), .DEPTH(1 << CHOOSER_INDEX_BITS)) u_chooser (
      .clock   (clock),
      .wr_en   (ch_we),
      .wr_addr (ch_wa),
      .wr_data (ch_wd),
      .rd_addr (ch_addr),
      .rd_data (ch_rd)
   );

   tbp_ram #(.WIDTH(2), .DEPTH(1 << GLOBAL_HISTORY_BITS)) u_global_ctr (
      .clock   (clock),
      .wr_en   (gc_we),
      .wr_addr (gc_wa),
      .wr_data (gc_wd),
      .rd_addr (ghist_ff),
      .rd_data (gc_rd)
   );

   tbp_ram #(.WIDTH(LOCAL_HISTORY_BITS), .DEPTH(1 << LOCAL_INDEX_BITS)) u_local_hist (
      .clock   (clock),
      .wr_en   (lh_we),
      .wr_addr (lh_wa),
      .wr_data (lh_wd),
      .rd_addr (lh_addr),
      .rd_data (lh_rd)
   );

   tbp_ram #(.WIDTH(3), .DEPTH(1 << LOCAL_HISTORY_BITS)) u_local_ctr (
      .clock   (clock),
      .wr_en   (lc_we),
      .wr_addr (lc_wa),
      .wr_data (lc_wd),
      .rd_addr (lh_rd),
      .rd_data (lc_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ghist_ff     <= '1;
         mode_ff      <= COUNTER_MODE_JUMP;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            mode_ff <= counter_mode_type'(csr_write_data);
         end
         if (rsp_valid_ff && !rsp_stall && !upd_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  pc_ff    <= req_payload.branch_pc;
                  taken_ff <= req_payload.outcome_taken;
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               if (upd_go) begin
                  ghist_ff                  <= ghist_in;
                  rsp_valid_ff              <= 1'b1;
                  rsp_ff.predicted_taken    <= pred;
                  rsp_ff.used_global        <= use_global;
                  rsp_ff.prediction_correct <= right;
                  state_ff                  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hdl/tbp_ram.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
